FILE: design/mmss_pkg.sv
// Package for the memory-mode soft switch tracker.
// Holds flag positions, switch index codes and the status and pair switch decodes.
// No dependencies.
`default_nettype none

package mmss_pkg;

  // Number of memory-mode flags and the width of a flag position.
  localparam int unsigned NumFlags = 11;

  typedef logic [NumFlags-1:0] mode_flags_t;
  typedef logic [3:0]          flag_pos_t;
  typedef logic [7:0]          switch_index_t;
  typedef logic [7:0]          byte_t;

  // Flag positions within the mode register.
  localparam flag_pos_t FL_80STORE   = 4'd0;
  localparam flag_pos_t FL_AUXREAD   = 4'd1;
  localparam flag_pos_t FL_AUXWRITE  = 4'd2;
  localparam flag_pos_t FL_INTCXROM  = 4'd3;
  localparam flag_pos_t FL_ALTZP     = 4'd4;
  localparam flag_pos_t FL_SLOTC3ROM = 4'd5;
  localparam flag_pos_t FL_PAGE2     = 4'd6;
  localparam flag_pos_t FL_HIRES     = 4'd7;
  localparam flag_pos_t FL_BANK      = 4'd8;
  localparam flag_pos_t FL_HIGHRAM   = 4'd9;
  localparam flag_pos_t FL_WRITERAM  = 4'd10;

  // Switch indices within the I/O page.
  localparam switch_index_t IDX_KBD       = 8'h00;
  localparam switch_index_t IDX_PAIR_LAST = 8'h0B;
  localparam switch_index_t IDX_KBD_CLR   = 8'h10;
  localparam switch_index_t IDX_RD_AUXRD  = 8'h13;
  localparam switch_index_t IDX_RD_AUXWR  = 8'h14;
  localparam switch_index_t IDX_RD_CXROM  = 8'h15;
  localparam switch_index_t IDX_RD_ALTZP  = 8'h16;
  localparam switch_index_t IDX_RD_C3ROM  = 8'h17;
  localparam switch_index_t IDX_RD_80STO  = 8'h18;
  localparam switch_index_t IDX_RD_PAGE2  = 8'h1C;
  localparam switch_index_t IDX_RD_HIRES  = 8'h1D;
  localparam switch_index_t IDX_PAGE2_OFF = 8'h54;
  localparam switch_index_t IDX_PAGE2_ON  = 8'h55;
  localparam switch_index_t IDX_HIRES_OFF = 8'h56;
  localparam switch_index_t IDX_HIRES_ON  = 8'h57;
  localparam switch_index_t IDX_LC_FIRST  = 8'h80;
  localparam switch_index_t IDX_LC_LAST   = 8'h8F;

  // Result of decoding a status switch read.
  typedef struct packed {
    logic      hit;
    flag_pos_t pos;
  } status_dec_t;

  // Flag driven by a status switch index; hit is low if the index is not one.
  function automatic status_dec_t status_decode(input switch_index_t idx);
    status_dec_t d;
    d.hit = 1'b1;
    d.pos = FL_80STORE;
    unique case (idx)
      IDX_RD_AUXRD: d.pos = FL_AUXREAD;
      IDX_RD_AUXWR: d.pos = FL_AUXWRITE;
      IDX_RD_CXROM: d.pos = FL_INTCXROM;
      IDX_RD_ALTZP: d.pos = FL_ALTZP;
      IDX_RD_C3ROM: d.pos = FL_SLOTC3ROM;
      IDX_RD_80STO: d.pos = FL_80STORE;
      IDX_RD_PAGE2: d.pos = FL_PAGE2;
      IDX_RD_HIRES: d.pos = FL_HIRES;
      default:      d.hit = 1'b0;
    endcase
    return d;
  endfunction

  // Flag of an off/on pair at indices up to IDX_PAIR_LAST.
  function automatic flag_pos_t pair_decode(input switch_index_t idx);
    flag_pos_t p;
    unique case (idx[3:1])
      3'd0:    p = FL_80STORE;
      3'd1:    p = FL_AUXREAD;
      3'd2:    p = FL_AUXWRITE;
      3'd3:    p = FL_INTCXROM;
      3'd4:    p = FL_ALTZP;
      default: p = FL_SLOTC3ROM;
    endcase
    return p;
  endfunction

endpackage : mmss_pkg

`default_nettype wire

FILE: design/memory_mode_soft_switch_tracker.sv
// Memory-mode soft switch tracker: top level.
// Depends on mmss_pkg for flag positions, switch indices and decode functions.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | sink      | in_valid / in_ready  | phase, is_read, switch_index, data
//  out     | source    | out_valid / out_ready| mode_flags, keyboard_byte
//
// Each item is decoded against the flag state in the cycle it is accepted; the
// new state and its result are registered at that edge, so the result appears
// in the next cycle. One item per cycle is sustained while results are taken.
// A result waiting in the output register holds its values; a new item is
// accepted in the same cycle that the waiting result is taken.
// Synchronous reset clears all flags, the keyboard latch and the pending slot.
`default_nettype none

module memory_mode_soft_switch_tracker
  import mmss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        phase,
  input  wire logic        is_read,
  input  wire logic [7:0]  switch_index,
  input  wire logic [7:0]  data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [10:0]      mode_flags,
  output logic [7:0]       keyboard_byte
);

  // Architectural state.
  mode_flags_t mode_reg, mode_reg_next;
  logic        prewrite, prewrite_next;
  logic        pend_valid, pend_valid_next;
  logic        pend_kbd, pend_kbd_next;
  flag_pos_t   pend_pos, pend_pos_next;
  byte_t       kbd_latch, kbd_latch_next;

  logic        in_fire;
  status_dec_t sdec;

  // The output register frees up when it is empty or being taken.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign sdec     = status_decode(switch_index);

  // Next-state decode for one item.
  always_comb begin
    mode_reg_next   = mode_reg;
    prewrite_next   = prewrite;
    pend_valid_next = pend_valid;
    pend_kbd_next   = pend_kbd;
    pend_pos_next   = pend_pos;
    kbd_latch_next  = kbd_latch;
    if (phase) begin
      // Data phase serves the armed slot once.
      if (pend_valid) begin
        if (pend_kbd) begin
          kbd_latch_next = data;
        end else begin
          mode_reg_next[pend_pos] = data[7];
        end
        pend_valid_next = 1'b0;
      end
    end else if (switch_index == IDX_KBD && is_read) begin
      pend_valid_next = 1'b1;
      pend_kbd_next   = 1'b1;
    end else if (switch_index <= IDX_PAIR_LAST) begin
      if (!is_read) begin
        mode_reg_next[pair_decode(switch_index)] = switch_index[0];
      end
    end else if (switch_index == IDX_KBD_CLR) begin
      kbd_latch_next[7] = 1'b0;
    end else if (sdec.hit) begin
      if (is_read) begin
        pend_valid_next = 1'b1;
        pend_kbd_next   = 1'b0;
        pend_pos_next   = sdec.pos;
      end
    end else if (switch_index >= IDX_PAGE2_OFF && switch_index <= IDX_HIRES_ON) begin
      if (switch_index < IDX_HIRES_OFF) begin
        mode_reg_next[FL_PAGE2] = switch_index[0];
      end else begin
        mode_reg_next[FL_HIRES] = switch_index[0];
      end
    end else if (switch_index >= IDX_LC_FIRST && switch_index <= IDX_LC_LAST) begin
      // Language card: bank, read RAM and the double-read write enable.
      if (is_read) begin
        mode_reg_next[FL_BANK]    = switch_index[3];
        mode_reg_next[FL_HIGHRAM] = (switch_index[1] == switch_index[0]);
        if (switch_index[0]) begin
          if (prewrite) begin
            mode_reg_next[FL_WRITERAM] = 1'b1;
          end
        end else begin
          mode_reg_next[FL_WRITERAM] = 1'b0;
        end
        prewrite_next = switch_index[0];
      end
    end
  end

  // Control state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg   <= '0;
      prewrite   <= 1'b0;
      pend_valid <= 1'b0;
      pend_kbd   <= 1'b0;
      pend_pos   <= FL_80STORE;
      kbd_latch  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_reg   <= mode_reg_next;
        prewrite   <= prewrite_next;
        pend_valid <= pend_valid_next;
        pend_kbd   <= pend_kbd_next;
        pend_pos   <= pend_pos_next;
        kbd_latch  <= kbd_latch_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // Result register, loaded with the state after the item.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_flags    <= mode_reg_next;
      keyboard_byte <= kbd_latch_next;
    end
  end

endmodule : memory_mode_soft_switch_tracker

`default_nettype wire

FILE: design/mmss_checker.sv
// Port-level checker for the memory-mode soft switch tracker, with its bind.
// Depends on mmss_pkg for switch index codes.
`default_nettype none

module mmss_checker
  import mmss_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        phase,
  input wire logic [7:0]  switch_index,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [10:0] mode_flags,
  input wire logic [7:0]  keyboard_byte
);

  // A waiting result holds its values.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mode_flags) && $stable(keyboard_byte))
    else $error("result changed while stalled");

  // An empty output register never blocks the input.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Every accepted item gives a result in the next cycle.
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  // Any address-phase access to the strobe-clear switch clears keyboard bit 7.
  a_kbd_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !phase && switch_index == IDX_KBD_CLR |=> !keyboard_byte[7])
    else $error("keyboard strobe not cleared");

  // Any address-phase access to the page2 on switch sets page2 in the result.
  a_page2_on: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !phase && switch_index == IDX_PAGE2_ON
    |=> mode_flags[FL_PAGE2])
    else $error("page2 not set");

endmodule : mmss_checker

bind memory_mode_soft_switch_tracker mmss_checker u_mmss_checker (.*);

`default_nettype wire
